// File: design/rgcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgcg_pkg: shared definitions of the random glissando curve generator
// Constants, register indexes, datapath op codes and the structs that link
// the controller, the datapath and the random number generator.
// ----------------------------------------------------------------------------
package rgcg_pkg;

	localparam int PHASE_BITS_DEF = 24;

	localparam int          MT_N        = 624;
	localparam int          MT_M        = 397;
	localparam int          MT_IDXW     = 10;
	localparam logic [31:0] MT_MATRIX   = 32'h9908_B0DF;
	localparam logic [31:0] MT_SEED_MUL = 32'd1812433253;
	localparam logic [31:0] SEED_DEF    = 32'd5489;

	localparam logic [31:0] POW_BIAS  = 32'd1072632447;
	localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
	localparam logic [23:0] POWER_ONE = 24'h01_0000;
	localparam logic [23:0] POWER_MAX = 24'hFF_FFFF;

	localparam logic [2:0] REG_START_LOW  = 3'd0;
	localparam logic [2:0] REG_START_HIGH = 3'd1;
	localparam logic [2:0] REG_END_LOW    = 3'd2;
	localparam logic [2:0] REG_END_HIGH   = 3'd3;
	localparam logic [2:0] REG_CURVE_EXP  = 3'd4;
	localparam logic [2:0] REG_CURVE_SPR  = 3'd5;
	localparam logic [2:0] REG_RNG_SEED   = 3'd6;

	localparam logic [3:0] OP_IDLE  = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;
	localparam logic [3:0] OP_SCALE = 4'd2;
	localparam logic [3:0] OP_SET   = 4'd3;
	localparam logic [3:0] OP_LOG   = 4'd4;
	localparam logic [3:0] OP_EXP1  = 4'd5;
	localparam logic [3:0] OP_EXP2  = 4'd6;
	localparam logic [3:0] OP_EXP3  = 4'd7;
	localparam logic [3:0] OP_NORM  = 4'd8;
	localparam logic [3:0] OP_POW   = 4'd9;
	localparam logic [3:0] OP_HP    = 4'd10;
	localparam logic [3:0] OP_TERM  = 4'd11;
	localparam logic [3:0] OP_SHIFT = 4'd12;
	localparam logic [3:0] OP_SUM   = 4'd13;

	localparam logic [1:0] DRAW_START  = 2'd0;
	localparam logic [1:0] DRAW_END    = 2'd1;
	localparam logic [1:0] DRAW_OFFSET = 2'd2;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] sel;
	} dp_cmd_t;

	typedef struct packed {
		logic fresh;
		logic zero;
		logic norm_done;
	} dp_stat_t;

	typedef struct packed {
		logic ready;
		logic done;
	} rng_stat_t;

	typedef struct packed {
		logic signed [31:0] start_min;
		logic signed [31:0] start_max;
		logic signed [31:0] end_min;
		logic signed [31:0] end_max;
		logic signed [23:0] curve_exponent;
		logic [22:0]        curve_spread;
	} cfg_t;

endpackage
`default_nettype wire

// File: design/random_glissando_curve_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// random_glissando_curve_generator: random curved glide from a ramp phase
// A zero phase skips the curve steps; any other phase goes through the phase
// normalizer, which shifts up to four bits a cycle, and the curve steps; a beat
// that starts a glide first makes three twister draws and runs the exp steps.
// One beat at a time; the next is taken only after the result is registered.
// After reset and after each seed write the twister state is rebuilt, one word
// a cycle, during which no input beat is taken.
// ----------------------------------------------------------------------------
module random_glissando_curve_generator import rgcg_pkg::*; #(
	parameter int PHASE_FRAC_BITS = PHASE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [4:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [PHASE_FRAC_BITS-1:0] phase,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [31:0]                level,
	output logic                       new_glide
);

	cfg_t        cfg_q;
	logic [31:0] seed_q;
	logic        wr_en;
	logic [2:0]  reg_idx;
	logic        reseed;
	rng_stat_t   rng_stat;
	logic        draw_req;
	logic [31:0] word;
	dp_stat_t    dp_stat;
	dp_cmd_t     cmd;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign reseed  = wr_en && (reg_idx == REG_RNG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= '0;
			seed_q <= SEED_DEF;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_START_LOW:  cfg_q.start_min      <= pwdata;
				REG_START_HIGH: cfg_q.start_max      <= pwdata;
				REG_END_LOW:    cfg_q.end_min        <= pwdata;
				REG_END_HIGH:   cfg_q.end_max        <= pwdata;
				REG_CURVE_EXP:  cfg_q.curve_exponent <= pwdata[23:0];
				REG_CURVE_SPR:  cfg_q.curve_spread   <= pwdata[22:0];
				REG_RNG_SEED:   seed_q               <= pwdata;
				default:        seed_q               <= seed_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START_LOW:  prdata = cfg_q.start_min;
			REG_START_HIGH: prdata = cfg_q.start_max;
			REG_END_LOW:    prdata = cfg_q.end_min;
			REG_END_HIGH:   prdata = cfg_q.end_max;
			REG_CURVE_EXP:  prdata = 32'(cfg_q.curve_exponent);
			REG_CURVE_SPR:  prdata = {9'b0, cfg_q.curve_spread};
			REG_RNG_SEED:   prdata = seed_q;
			default:        prdata = '0;
		endcase
	end

	rgcg_twister u_twister (
		.clk      (clk),
		.arst_n   (arst_n),
		.seed     (seed_q),
		.reseed   (reseed),
		.draw_req (draw_req),
		.stat     (rng_stat),
		.word     (word)
	);

	rgcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rng_stat  (rng_stat),
		.draw_req  (draw_req),
		.dp_stat   (dp_stat),
		.cmd       (cmd)
	);

	rgcg_datapath #(
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.phase     (phase),
		.cfg       (cfg_q),
		.word      (word),
		.cmd       (cmd),
		.stat      (dp_stat),
		.level     (level),
		.new_glide (new_glide)
	);

`ifndef SYNTHESIS
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input beat taken while the previous one is in work");

	a_reseed_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		reseed |=> !in_ready)
		else $error("input ready while the twister state is rebuilt");

	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rng_stat.done |-> !in_ready)
		else $error("draw finished while no beat is in work");
`endif

endmodule
`default_nettype wire

// File: design/rgcg_twister.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgcg_twister: mersenne twister word generator
// Holds the 624-word state in a memory. Seeding writes one word per cycle.
// Each draw regenerates the word it uses from three reads, then tempers it.
// ----------------------------------------------------------------------------
module rgcg_twister import rgcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] seed,
	input  logic        reseed,
	input  logic        draw_req,
	output rng_stat_t   stat,
	output logic [31:0] word
);

	localparam logic [2:0] T_SEED = 3'd0;
	localparam logic [2:0] T_IDLE = 3'd1;
	localparam logic [2:0] T_RD1  = 3'd2;
	localparam logic [2:0] T_RD2  = 3'd3;
	localparam logic [2:0] T_WR   = 3'd4;

	logic [2:0]         state_q;
	logic [MT_IDXW-1:0] idx_q;
	logic [MT_IDXW-1:0] pos_q;
	logic               done_q;
	logic [31:0]        prev_q;
	logic [31:0]        a_q;
	logic [31:0]        b_q;
	logic [31:0]        rdata_q;
	logic [31:0]        word_q;
	logic [31:0]        mem [MT_N];

	logic [MT_IDXW-1:0] pos1;
	logic [MT_IDXW:0]   posm_sum;
	logic [MT_IDXW-1:0] posm;
	logic [MT_IDXW-1:0] raddr;
	logic [MT_IDXW-1:0] waddr;
	logic [31:0]        wdata;
	logic               we;
	logic [31:0]        seed_mix;
	logic [31:0]        seed_word;
	logic [31:0]        mix_v;
	logic [31:0]        twist_n;
	logic [31:0]        temp_a;
	logic [31:0]        temp_b;
	logic [31:0]        temp_c;
	logic [31:0]        temp_d;

	always_comb begin
		pos1     = (pos_q == MT_IDXW'(MT_N - 1)) ? '0 : pos_q + 1'b1;
		posm_sum = {1'b0, pos_q} + (MT_IDXW + 1)'(MT_M);
		posm     = (posm_sum >= (MT_IDXW + 1)'(MT_N)) ?
			MT_IDXW'(posm_sum - (MT_IDXW + 1)'(MT_N)) : posm_sum[MT_IDXW-1:0];
		unique case (state_q)
			T_IDLE:  raddr = pos_q;
			T_RD1:   raddr = pos1;
			default: raddr = posm;
		endcase
		seed_mix  = prev_q ^ (prev_q >> 30);
		seed_word = (idx_q == '0) ? seed :
			32'(MT_SEED_MUL * seed_mix) + 32'(idx_q);
		mix_v     = {a_q[31], b_q[30:0]};
		twist_n   = rdata_q ^ (mix_v >> 1) ^ (mix_v[0] ? MT_MATRIX : 32'd0);
		temp_a    = twist_n ^ (twist_n >> 11);
		temp_b    = temp_a ^ ((temp_a << 7) & 32'h9D2C_5680);
		temp_c    = temp_b ^ ((temp_b << 15) & 32'hEFC6_0000);
		temp_d    = temp_c ^ (temp_c >> 18);
		we        = (state_q == T_SEED) || (state_q == T_WR);
		waddr     = (state_q == T_SEED) ? idx_q : pos_q;
		wdata     = (state_q == T_SEED) ? seed_word : twist_n;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == T_SEED) begin
			prev_q <= seed_word;
		end
		if (state_q == T_RD1) begin
			a_q <= rdata_q;
		end
		if (state_q == T_RD2) begin
			b_q <= rdata_q;
		end
		if (state_q == T_WR) begin
			word_q <= temp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_SEED;
			idx_q   <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == T_WR) && !reseed;
			if (reseed) begin
				state_q <= T_SEED;
				idx_q   <= '0;
			end else begin
				unique case (state_q)
					T_SEED: begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == MT_IDXW'(MT_N - 1)) begin
							state_q <= T_IDLE;
							pos_q   <= '0;
						end
					end
					T_IDLE: begin
						if (draw_req) begin
							state_q <= T_RD1;
						end
					end
					T_RD1: state_q <= T_RD2;
					T_RD2: state_q <= T_WR;
					T_WR: begin
						state_q <= T_IDLE;
						pos_q   <= pos1;
					end
					default: state_q <= T_IDLE;
				endcase
			end
		end
	end

	assign stat.ready = (state_q == T_IDLE);
	assign stat.done  = done_q;
	assign word       = word_q;

endmodule
`default_nettype wire

// File: design/rgcg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgcg_datapath: glide state and curve arithmetic
// Scales random draws, evaluates the exp2 approximation for the curve power,
// normalizes the phase and forms the saturated output level, one op a cycle.
// ----------------------------------------------------------------------------
module rgcg_datapath import rgcg_pkg::*; #(
	parameter int PHASE_FRAC_BITS = PHASE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [PHASE_FRAC_BITS-1:0] phase,
	input  cfg_t                       cfg,
	input  logic [31:0]                word,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	output logic [31:0]                level,
	output logic                       new_glide
);

	localparam int NW  = PHASE_FRAC_BITS + 20;
	localparam int LZW = $clog2(PHASE_FRAC_BITS);

	logic [PHASE_FRAC_BITS:0] prev_q;
	logic                     fresh_q;
	logic                     zero_q;
	logic signed [31:0]       start_q;
	logic signed [32:0]       span_q;
	logic [23:0]              power_q;

	logic signed [66:0] sprod_q;
	logic signed [25:0] x_q;
	logic signed [27:0] y_q;
	logic [14:0]        t1_q;
	logic [32:0]        t2_q;
	logic [NW-1:0]      norm_q;
	logic [LZW-1:0]     lz_q;
	logic signed [56:0] pm_q;
	logic signed [41:0] hp_q;
	logic signed [54:0] tm_q;
	logic signed [22:0] s_q;
	logic               flush_q;
	logic signed [63:0] term_q;
	logic [31:0]        level_q;
	logic               glide_q;

	logic signed [32:0] lo33;
	logic signed [32:0] hi33;
	logic signed [33:0] diff34;
	logic signed [66:0] sprod;
	logic signed [34:0] v35;
	logic signed [58:0] lprod;
	logic signed [11:0] k;
	logic signed [11:0] nk;
	logic [15:0]        f;
	logic [31:0]        e1_prod;
	logic [32:0]        e2_prod;
	logic [16:0]        m;
	logic [24:0]        m_left;
	logic [23:0]        power_n;
	logic [3:0]         top4;
	logic [10:0]        e11;
	logic [30:0]        h31;
	logic signed [31:0] l32;
	logic signed [56:0] pm;
	logic signed [56:0] pm_adj;
	logic signed [41:0] hp;
	logic [20:0]        mant;
	logic signed [54:0] tm;
	logic signed [22:0] s23;
	logic signed [22:0] ns;
	logic [5:0]         sh;
	logic signed [63:0] t64;
	logic signed [63:0] term_n;
	logic signed [63:0] sum;
	logic [31:0]        level_n;

	always_comb begin
		unique case (cmd.sel)
			DRAW_START: begin
				lo33 = 33'(cfg.start_min);
				hi33 = 33'(cfg.start_max);
			end
			DRAW_END: begin
				lo33 = 33'(cfg.end_min);
				hi33 = 33'(cfg.end_max);
			end
			default: begin
				lo33 = -$signed({10'b0, cfg.curve_spread});
				hi33 = $signed({10'b0, cfg.curve_spread});
			end
		endcase
		diff34 = 34'(hi33) - 34'(lo33);
		sprod  = diff34 * $signed({1'b0, word});
		v35    = 35'(lo33) + sprod_q[66:32];

		lprod   = 59'(x_q) * $signed({27'b0, LOG2E_Q30});
		k       = y_q[27:16];
		nk      = -k;
		f       = y_q[15:0];
		e1_prod = 32'(f) * 32'd22490;
		e2_prod = 33'(f) * 33'(17'd43046 + 17'(t1_q));
		m       = 17'h1_0000 + t2_q[32:16];
		m_left  = 25'(m) << k[2:0];
		if (k >= 12'sd8) begin
			power_n = POWER_MAX;
		end else if (k < -12'sd17) begin
			power_n = '0;
		end else if (k >= 12'sd0) begin
			power_n = (m_left > 25'(POWER_MAX)) ? POWER_MAX : m_left[23:0];
		end else begin
			power_n = 24'(m >> nk[4:0]);
		end

		top4   = norm_q[NW-1 -: 4];
		e11    = 11'd1022 - 11'(lz_q);
		h31    = {e11, norm_q[NW-2 -: 20]};
		l32    = $signed({1'b0, h31}) - $signed(POW_BIAS);
		pm     = $signed({1'b0, power_q}) * l32;
		pm_adj = pm_q[56] ? pm_q + 57'sd65535 : pm_q;
		hp     = 42'($signed(pm_adj[56:16])) + $signed({10'b0, POW_BIAS});
		mant   = {1'b1, hp_q[19:0]};
		tm     = span_q * $signed({1'b0, mant});
		s23    = 23'(hp_q[41:20]) - 23'sd1043;

		t64 = 64'(tm_q);
		ns  = -s_q;
		sh  = (ns > 23'sd63) ? 6'd63 : ns[5:0];
		if (flush_q) begin
			term_n = '0;
		end else if (s_q <= 23'sd0) begin
			term_n = t64 >>> sh;
		end else if (tm_q == '0) begin
			term_n = '0;
		end else if (s_q > 23'sd8) begin
			term_n = tm_q[54] ? -(64'sd1 <<< 62) : (64'sd1 <<< 62);
		end else begin
			term_n = t64 <<< s_q[3:0];
		end

		sum = 64'(start_q) + (zero_q ? 64'sd0 : term_q);
		if (sum > 64'sd2147483647) begin
			level_n = 32'h7FFF_FFFF;
		end else if (sum < -64'sd2147483648) begin
			level_n = 32'h8000_0000;
		end else begin
			level_n = sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= (PHASE_FRAC_BITS + 1)'(1) << PHASE_FRAC_BITS;
			start_q <= '0;
			span_q  <= '0;
			power_q <= POWER_ONE;
		end else begin
			if (cmd.op == OP_LOAD) begin
				prev_q <= {1'b0, phase};
			end
			if (cmd.op == OP_SET && cmd.sel == DRAW_START) begin
				start_q <= v35[31:0];
			end
			if (cmd.op == OP_SET && cmd.sel == DRAW_END) begin
				span_q <= v35[32:0] - 33'(start_q);
			end
			if (cmd.op == OP_EXP3) begin
				power_q <= power_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				fresh_q <= {1'b0, phase} < prev_q;
				zero_q  <= (phase == '0);
				norm_q  <= {phase, 20'b0};
				lz_q    <= '0;
			end
			OP_SCALE: sprod_q <= sprod;
			OP_SET: begin
				if (cmd.sel == DRAW_OFFSET) begin
					x_q <= 26'(cfg.curve_exponent) + v35[25:0];
				end
			end
			OP_LOG:  y_q  <= lprod[57:30];
			OP_EXP1: t1_q <= e1_prod[30:16];
			OP_EXP2: t2_q <= e2_prod;
			OP_NORM: begin
				priority if (top4 == 4'b0000) begin
					norm_q <= norm_q << 4;
					lz_q   <= lz_q + LZW'(4);
				end else if (top4[3]) begin
					norm_q <= norm_q;
				end else if (top4[2]) begin
					norm_q <= norm_q << 1;
					lz_q   <= lz_q + LZW'(1);
				end else if (top4[1]) begin
					norm_q <= norm_q << 2;
					lz_q   <= lz_q + LZW'(2);
				end else begin
					norm_q <= norm_q << 3;
					lz_q   <= lz_q + LZW'(3);
				end
			end
			OP_POW: pm_q <= pm;
			OP_HP:  hp_q <= hp;
			OP_TERM: begin
				tm_q    <= tm;
				s_q     <= s23;
				flush_q <= hp_q < 42'sd1048576;
			end
			OP_SHIFT: term_q <= term_n;
			OP_SUM: begin
				level_q <= level_n;
				glide_q <= fresh_q;
			end
			default: begin
				glide_q <= glide_q;
			end
		endcase
	end

	assign stat.fresh     = fresh_q;
	assign stat.zero      = zero_q;
	assign stat.norm_done = norm_q[NW-1];
	assign level          = level_q;
	assign new_glide      = glide_q;

endmodule
`default_nettype wire

// File: design/rgcg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgcg_ctrl: sequencing state machine
// Accepts one phase beat, runs the glide start and curve steps on the
// datapath and holds the output beat until it is taken.
// ----------------------------------------------------------------------------
module rgcg_ctrl import rgcg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  rng_stat_t rng_stat,
	output logic      draw_req,
	input  dp_stat_t  dp_stat,
	output dp_cmd_t   cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_DREQ  = 4'd2;
	localparam logic [3:0] S_DWAIT = 4'd3;
	localparam logic [3:0] S_DSET  = 4'd4;
	localparam logic [3:0] S_LOG   = 4'd5;
	localparam logic [3:0] S_E1    = 4'd6;
	localparam logic [3:0] S_E2    = 4'd7;
	localparam logic [3:0] S_E3    = 4'd8;
	localparam logic [3:0] S_NORM  = 4'd9;
	localparam logic [3:0] S_POW   = 4'd10;
	localparam logic [3:0] S_HP    = 4'd11;
	localparam logic [3:0] S_TERM  = 4'd12;
	localparam logic [3:0] S_SHIFT = 4'd13;
	localparam logic [3:0] S_SUM   = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_n;
	logic [1:0] cnt_q;
	logic [1:0] cnt_n;
	logic       out_valid_q;
	logic       out_load;

	always_comb begin
		state_n  = state_q;
		cnt_n    = cnt_q;
		cmd.op   = OP_IDLE;
		cmd.sel  = cnt_q;
		draw_req = 1'b0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = rng_stat.ready;
				if (in_valid && rng_stat.ready) begin
					cmd.op  = OP_LOAD;
					state_n = S_CHK;
				end
			end
			S_CHK: begin
				cnt_n   = DRAW_START;
				state_n = dp_stat.fresh ? S_DREQ : S_NORM;
			end
			S_DREQ: begin
				draw_req = 1'b1;
				state_n  = S_DWAIT;
			end
			S_DWAIT: begin
				if (rng_stat.done) begin
					cmd.op  = OP_SCALE;
					state_n = S_DSET;
				end
			end
			S_DSET: begin
				cmd.op = OP_SET;
				if (cnt_q == DRAW_OFFSET) begin
					state_n = S_LOG;
				end else begin
					cnt_n   = cnt_q + 1'b1;
					state_n = S_DREQ;
				end
			end
			S_LOG: begin
				cmd.op  = OP_LOG;
				state_n = S_E1;
			end
			S_E1: begin
				cmd.op  = OP_EXP1;
				state_n = S_E2;
			end
			S_E2: begin
				cmd.op  = OP_EXP2;
				state_n = S_E3;
			end
			S_E3: begin
				cmd.op  = OP_EXP3;
				state_n = S_NORM;
			end
			S_NORM: begin
				priority if (dp_stat.zero) begin
					state_n = S_SUM;
				end else if (dp_stat.norm_done) begin
					state_n = S_POW;
				end else begin
					cmd.op = OP_NORM;
				end
			end
			S_POW: begin
				cmd.op  = OP_POW;
				state_n = S_HP;
			end
			S_HP: begin
				cmd.op  = OP_HP;
				state_n = S_TERM;
			end
			S_TERM: begin
				cmd.op  = OP_TERM;
				state_n = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.op  = OP_SHIFT;
				state_n = S_SUM;
			end
			S_SUM: begin
				if (!out_valid_q || out_ready) begin
					cmd.op   = OP_SUM;
					out_load = 1'b1;
					state_n  = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= DRAW_START;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: tb/random_glissando_curve_generator_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// random_glissando_curve_generator_tb: self-checking test of the glide block
// Runs a short table of directed phase beats and then random ramp sequences
// under several register settings and handshake idling patterns. Every output
// beat is compared with an expected beat: the typed value for the first table's
// rows, else a predictor that keeps its own twister, glide state and curve arithmetic.
// ----------------------------------------------------------------------------
module random_glissando_curve_generator_tb import rgcg_pkg::*;;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] level;
		logic        glide;
	} glide_beat_t;

	typedef struct {
		logic [23:0] phase;
		bit          typed;
		logic [31:0] level;
		logic        glide;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [23:0] phase;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] level;
	logic        new_glide;

	random_glissando_curve_generator i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .phase(phase),
		.out_valid(out_valid), .out_ready(out_ready),
		.level(level), .new_glide(new_glide)
	);

	// Predictor state.
	cfg_t        cfg;
	logic [31:0] seed_reg;
	logic [24:0] last_phase;
	longint      glide_start;
	longint      glide_span;
	logic [23:0] power;
	logic [31:0] twister [MT_N];
	int          twister_pos;

	glide_beat_t expected_beats [$];
	int          error_count;
	int          stall_pct;
	int          idle_pct;
	int          quiet_cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	function automatic void seed_twister();
		logic [31:0] prev;
		twister[0] = seed_reg;
		for (int i = 1; i < MT_N; i++) begin
			prev = twister[i-1];
			twister[i] = MT_SEED_MUL * (prev ^ (prev >> 30)) + i;
		end
		twister_pos = MT_N;
	endfunction

	function automatic logic [31:0] twister_draw();
		logic [31:0] v;
		logic [31:0] n;
		logic [31:0] y;
		if (twister_pos >= MT_N) begin
			for (int i = 0; i < MT_N; i++) begin
				v = (twister[i] & 32'h8000_0000) | (twister[(i + 1) % MT_N] & 32'h7FFF_FFFF);
				n = twister[(i + MT_M) % MT_N] ^ (v >> 1);
				if (v[0]) begin
					n ^= MT_MATRIX;
				end
				twister[i] = n;
			end
			twister_pos = 0;
		end
		y = twister[twister_pos];
		twister_pos++;
		y ^= y >> 11;
		y ^= (y << 7) & 32'h9D2C_5680;
		y ^= (y << 15) & 32'hEFC6_0000;
		y ^= y >> 18;
		return y;
	endfunction

	function automatic longint scaled_draw(input longint lo, input longint hi);
		bit [63:0] d;
		bit [63:0] prod;
		longint    diff;
		longint    q;
		d = {32'd0, twister_draw()};
		diff = hi - lo;
		if (diff >= 0) begin
			prod = 64'(diff) * d;
			q = longint'(prod >> 32);
		end else begin
			prod = 64'(-diff) * d;
			q = -longint'(prod >> 32) - ((prod[31:0] != 0) ? 1 : 0);
		end
		return lo + q;
	endfunction

	function automatic logic [23:0] exp_curve(input longint x);
		longint    y;
		longint    k;
		bit [63:0] f;
		bit [63:0] m;
		y = (x * longint'(LOG2E_Q30)) >>> 30;
		k = y >>> 16;
		f = 64'(y) & 64'hFFFF;
		if (k >= 8) begin
			return POWER_MAX;
		end
		if (k < -17) begin
			return '0;
		end
		m = 65536 + ((f * (43046 + ((22490 * f) >> 16))) >> 16);
		m = (k >= 0) ? (m << k) : (m >> (-k));
		return (m > 64'hFF_FFFF) ? POWER_MAX : m[23:0];
	endfunction

	function automatic longint curve_term(input logic [23:0] p);
		int     msb;
		longint rem;
		longint frac;
		longint h;
		longint prod;
		longint hp;
		longint t;
		longint s;
		if (p == 0) begin
			return 0;
		end
		msb = 0;
		while ((p >> (msb + 1)) != 0) begin
			msb++;
		end
		rem = longint'(p) - (longint'(1) << msb);
		frac = (msb <= 20) ? (rem << (20 - msb)) : (rem >> (msb - 20));
		h = (longint'(1023 + msb - PHASE_BITS_DEF) << 20) + (frac & 64'hFFFFF);
		prod = longint'(power) * (h - longint'(POW_BIAS));
		hp = prod / 65536 + longint'(POW_BIAS);
		if (hp < (longint'(1) << 20)) begin
			return 0;
		end
		t = glide_span * (longint'(1048576) + (hp & 64'hFFFFF));
		s = (hp >>> 20) - 1043;
		if (s <= 0) begin
			return t >>> ((-s > 62) ? 62 : -s);
		end
		if (t == 0) begin
			return 0;
		end
		if (s > 8) begin
			return (t > 0) ? (longint'(1) << 62) : -(longint'(1) << 62);
		end
		return t <<< s;
	endfunction

	function automatic glide_beat_t predict_glide(input logic [23:0] p);
		glide_beat_t r;
		longint      end_level;
		longint      lvl;
		r.glide = {1'b0, p} < last_phase;
		if (r.glide) begin
			glide_start = scaled_draw(cfg.start_min, cfg.start_max);
			end_level = scaled_draw(cfg.end_min, cfg.end_max);
			glide_span = end_level - glide_start;
			lvl = scaled_draw(-longint'(cfg.curve_spread), longint'(cfg.curve_spread));
			power = exp_curve(longint'(cfg.curve_exponent) + lvl);
		end
		lvl = glide_start + curve_term(p);
		if (lvl > 64'sd2147483647) begin
			lvl = 64'sd2147483647;
		end
		if (lvl < -64'sd2147483648) begin
			lvl = -64'sd2147483648;
		end
		last_phase = {1'b0, p};
		r.level = lvl[31:0];
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_START_LOW:  cfg.start_min = value;
			REG_START_HIGH: cfg.start_max = value;
			REG_END_LOW:    cfg.end_min = value;
			REG_END_HIGH:   cfg.end_max = value;
			REG_CURVE_EXP:  cfg.curve_exponent = value[23:0];
			REG_CURVE_SPR:  cfg.curve_spread = value[22:0];
			REG_RNG_SEED: begin
				seed_reg = value;
				seed_twister();
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] sl, input logic [31:0] sh,
			input logic [31:0] el, input logic [31:0] eh, input logic [23:0] ce,
			input logic [22:0] cs);
		write_reg(REG_START_LOW, sl);
		write_reg(REG_START_HIGH, sh);
		write_reg(REG_END_LOW, el);
		write_reg(REG_END_HIGH, eh);
		write_reg(REG_CURVE_EXP, {{8{ce[23]}}, ce});
		write_reg(REG_CURVE_SPR, {9'd0, cs});
	endtask

	task automatic send_phase(input logic [23:0] p, input bit typed,
			input glide_beat_t typed_beat);
		glide_beat_t predicted;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		phase    <= p;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predicted = predict_glide(p);
		expected_beats.push_back(typed ? typed_beat : predicted);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		glide_beat_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat", level, '0);
				end else begin
					want = expected_beats.pop_front();
					if (level !== want.level) begin
						report_mismatch("level", level, want.level);
					end
					if (new_glide !== want.glide) begin
						report_mismatch("new_glide", {31'd0, new_glide}, {31'd0, want.glide});
					end
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t   reset_rows [7];
		logic [23:0] edge_rows [9];
		logic [23:0] ramp;
		glide_beat_t tb;
		int          mode;

		arst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		paddr = '0; pwdata = '0; in_valid = 1'b0; phase = '0; out_ready = 1'b0;
		error_count = 0; stall_pct = 0; idle_pct = 0; quiet_cycles = 0;

		cfg = '0;
		seed_reg = SEED_DEF;
		seed_twister();
		last_phase = 25'h100_0000;
		glide_start = 0;
		glide_span = 0;
		power = POWER_ONE;

		reset_rows = '{
			'{24'h000000, 1, 32'd0, 1'b1}, '{24'hFFFFFF, 1, 32'd0, 1'b0},
			'{24'hFFFFFF, 1, 32'd0, 1'b0}, '{24'h000001, 1, 32'd0, 1'b1},
			'{24'h800000, 1, 32'd0, 1'b0}, '{24'h000000, 1, 32'd0, 1'b1},
			'{24'h000000, 1, 32'd0, 1'b0}};
		edge_rows = '{24'h000000, 24'h000001, 24'h000002, 24'h7FFFFF, 24'h800000,
			24'hFFFFFF, 24'h000010, 24'h555555, 24'hAAAAAA};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (reset_rows[i]) begin
			tb.level = reset_rows[i].level;
			tb.glide = reset_rows[i].glide;
			send_phase(reset_rows[i].phase, reset_rows[i].typed, tb);
		end
		drain();

		write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			24'h7F_FFFF, 23'h7F_FFFF);
		foreach (edge_rows[i]) begin
			send_phase(edge_rows[i], 0, '0);
		end
		drain();
		write_all(32'h0001_0000, 32'hFFFF_0000, 32'hFFF0_0000, 32'h0010_0000,
			24'h80_0000, 23'd0);
		foreach (edge_rows[i]) begin
			send_phase(edge_rows[i], 0, '0);
		end
		drain();
		write_reg(REG_RNG_SEED, 32'hFFFF_FFFF);

		for (int ph = 0; ph < 5; ph++) begin
			mode = ph % 4;
			idle_pct  = (mode == 1) ? 52 : (mode == 3) ? 27 : 0;
			stall_pct = (mode == 2) ? 52 : (mode == 3) ? 27 : 0;
			if ($urandom_range(1)) begin
				write_all(pick32(), pick32(), pick32(), pick32(),
					24'($signed($urandom_range(0, 393216)) - 196608),
					23'($urandom_range(0, 65536)));
			end else begin
				write_all(pick32(), pick32(), pick32(), pick32(), 24'($urandom),
					23'($urandom));
			end
			if (ph == 3) begin
				write_reg(REG_RNG_SEED, $urandom);
			end
			ramp = 24'($urandom);
			for (int n = 0; n < 126; n++) begin
				if ($urandom_range(9) == 0) begin
					ramp = 24'($urandom);
				end else if (ramp > 24'hFFFFFF - 24'h100000) begin
					ramp = 24'($urandom_range(0, 24'h0FFFFF));
				end else begin
					ramp = ramp + 24'($urandom_range(1, 24'h0FFFFF));
				end
				send_phase(ramp, 0, '0);
				if (mode == 0 && n % 40 == 39) begin
					in_valid <= 1'b0;
					while (expected_beats.size() != 0) begin
						@(posedge clk);
					end
				end
			end
			drain();
		end

		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire
